// ===== hdl/euler_to_rotation_matrix_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euler angle to rotation matrix block
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_TOP_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle, outside reset
`define E2R_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2r check failed");

// Check that an antecedent implies a consequent in the next cycle, outside reset
`define E2R_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2r check failed");

// Check a property that also holds while reset is asserted
`define E2R_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("e2r check failed");

`endif

// ===== hdl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg
// Types, constants and arithmetic helpers of the Euler angle to matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CORDIC_ITERS   = 30;
    localparam int Q30_W          = 32;
    localparam int XY_W           = 34;
    localparam int Z_W            = 33;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] Q30_ONE     = XY_W'(1073741824);

    typedef logic signed [Q30_W-1:0] q30_t;

    // Sine and cosine of the three angles
    typedef struct packed {
        q30_t sp;
        q30_t cp;
        q30_t sy;
        q30_t cy;
        q30_t sr;
        q30_t cr;
    } trig_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic [29:0] a;
        case (i)
            0:  a = 30'h20000000;  1:  a = 30'h12E4051E;  2:  a = 30'h09FB385B;
            3:  a = 30'h051111D4;  4:  a = 30'h028B0D43;  5:  a = 30'h0145D7E1;
            6:  a = 30'h00A2F61E;  7:  a = 30'h00517C55;  8:  a = 30'h0028BE53;
            9:  a = 30'h00145F2F;  10: a = 30'h000A2F98;  11: a = 30'h000517CC;
            12: a = 30'h00028BE6;  13: a = 30'h000145F3;  14: a = 30'h0000A2FA;
            15: a = 30'h0000517D;  16: a = 30'h000028BE;  17: a = 30'h0000145F;
            18: a = 30'h00000A30;  19: a = 30'h00000518;  20: a = 30'h0000028C;
            21: a = 30'h00000146;  22: a = 30'h000000A3;  23: a = 30'h00000051;
            24: a = 30'h00000029;  25: a = 30'h00000014;  26: a = 30'h0000000A;
            27: a = 30'h00000005;  28: a = 30'h00000003;  29: a = 30'h00000001;
            default: a = 30'h0;
        endcase
        return $signed({3'b000, a});
    endfunction

    // Q30 product rounded to nearest (half up) back to Q30
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return q30_t'(p >>> 30);
    endfunction

endpackage

// ===== hdl/e2r_cordic.sv =====
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC lane: one binary angle in, sine and cosine out.
// ----------------------------------------------------------------------------
module e2r_cordic #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output e2r_pkg::q30_t         sin_q,
    output e2r_pkg::q30_t         cos_q
);

    localparam int N = e2r_pkg::CORDIC_ITERS;
    localparam int XW = e2r_pkg::XY_W;
    localparam int ZW = e2r_pkg::Z_W;

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic [1:0]           quad_reg [0:N];
    logic [31:0]          phase;
    logic signed [XW-1:0] c_next, s_next;
    e2r_pkg::q30_t        sin_reg, cos_reg;

    // Place the angle at the top of a 32-bit phase
    assign phase = 32'({angle, 32'b0} >> ANGLE_BITS);

    // Load the first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= e2r_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({3'b000, phase[29:0]});
            quad_reg[0] <= phase[31:30];
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2r_pkg::atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2r_pkg::atan_step(i);
                end
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    // Unfold the quadrant
    always_comb
    begin
        case (quad_reg[N])
            2'd0:    begin c_next = x_reg[N];  s_next = y_reg[N];  end
            2'd1:    begin c_next = -y_reg[N]; s_next = x_reg[N];  end
            2'd2:    begin c_next = -x_reg[N]; s_next = -y_reg[N]; end
            default: begin c_next = y_reg[N];  s_next = -x_reg[N]; end
        endcase
    end

    function automatic e2r_pkg::q30_t clamp(input logic signed [XW-1:0] v);
        if (v > e2r_pkg::Q30_ONE)
            return e2r_pkg::q30_t'(e2r_pkg::Q30_ONE);
        else if (v < -e2r_pkg::Q30_ONE)
            return e2r_pkg::q30_t'(-e2r_pkg::Q30_ONE);
        return e2r_pkg::q30_t'(v);
    endfunction

    // Clamp into the unit range and register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= clamp(c_next);
            sin_reg <= clamp(s_next);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== hdl/e2r_front.sv =====
// ----------------------------------------------------------------------------
// e2r_front
// Accepts angle triples and forms their sines and cosines in three CORDIC lanes.
// ----------------------------------------------------------------------------
module e2r_front #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ANGLE_BITS-1:0]  pitch_angle,
    input  logic [ANGLE_BITS-1:0]  yaw_angle,
    input  logic [ANGLE_BITS-1:0]  roll_angle,
    input  e2r_pkg::queue_stat_t   q_stat,
    output logic                   push,
    output e2r_pkg::trig_t         trig
);

    localparam int LAT = e2r_pkg::CORDIC_ITERS + 2;

    logic [LAT-1:0] vld_reg;
    logic           en;

    // Advance unless a finished item cannot enter the queue
    assign en       = !(vld_reg[LAT-1] && q_stat.full);
    assign in_ready = en;
    assign push     = vld_reg[LAT-1] && !q_stat.full;

    // Track occupied stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk(clk), .en(en), .angle(pitch_angle), .sin_q(trig.sp), .cos_q(trig.cp)
    );
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk(clk), .en(en), .angle(yaw_angle), .sin_q(trig.sy), .cos_q(trig.cy)
    );
    e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk(clk), .en(en), .angle(roll_angle), .sin_q(trig.sr), .cos_q(trig.cr)
    );

endmodule

// ===== hdl/e2r_queue.sv =====
// ----------------------------------------------------------------------------
// e2r_queue
// Short FIFO of sine and cosine sets between the front and back parts.
// ----------------------------------------------------------------------------
module e2r_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  e2r_pkg::trig_t       wdata,
    input  logic                 pop,
    output e2r_pkg::trig_t       rdata,
    output e2r_pkg::queue_stat_t stat
);

    localparam int AW = e2r_pkg::QUEUE_AW;

    e2r_pkg::trig_t mem_reg [0:e2r_pkg::QUEUE_DEPTH-1];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign stat.full  = (count_reg == (AW+1)'(e2r_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Move pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/e2r_back.sv =====
// ----------------------------------------------------------------------------
// e2r_back
// Multiplies and sums the trig values into the nine matrix elements.
// ----------------------------------------------------------------------------
module e2r_back #(
    parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  e2r_pkg::trig_t         trig,
    input  e2r_pkg::queue_stat_t   q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [9*(FRAC_BITS+2)-1:0] out_data
);

    localparam int OW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [34:0] HALF = (SH > 0) ? (35'sd1 <<< ((SH > 0) ? SH - 1 : 0))
                                                   : 35'sd0;
    localparam logic signed [34:0] LIM  = 35'sd1 <<< FRAC_BITS;

    typedef e2r_pkg::q30_t q_t;

    logic en;
    logic v1_reg, v2_reg, vo_reg;
    q_t spcy_reg, spsy_reg, cpcy_reg, cpcr_reg, cpsr_reg, cpsy_reg;
    q_t sysr_reg, sycr_reg, cysr_reg, cycr_reg, sp1_reg, cr1_reg, sr1_reg;
    q_t a_reg, b_reg, c_reg, d_reg;
    q_t cpcy2_reg, cpcr2_reg, cpsr2_reg, cpsy2_reg;
    q_t sysr2_reg, sycr2_reg, cysr2_reg, cycr2_reg, sp2_reg;
    logic [9*OW-1:0] data_reg;
    logic [9*OW-1:0] data_next;

    // Round Q30 to the output step and saturate at plus or minus one
    function automatic logic [OW-1:0] to_out(input logic signed [32:0] q);
        logic signed [34:0] v;
        v = (35'(q) + HALF) >>> SH;
        if (v > LIM)
            v = LIM;
        else if (v < -LIM)
            v = -LIM;
        return v[OW-1:0];
    endfunction

    // Stall all stages while the result waits
    assign en  = !vo_reg || out_ready;
    assign pop = en && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !q_stat.empty;
            v2_reg <= v1_reg;
            vo_reg <= v2_reg;
        end
    end

    // Single and double products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spcy_reg <= e2r_pkg::mul_q30(trig.sp, trig.cy);
            spsy_reg <= e2r_pkg::mul_q30(trig.sp, trig.sy);
            cpcy_reg <= e2r_pkg::mul_q30(trig.cp, trig.cy);
            cpcr_reg <= e2r_pkg::mul_q30(trig.cp, trig.cr);
            cpsr_reg <= e2r_pkg::mul_q30(trig.cp, trig.sr);
            cpsy_reg <= e2r_pkg::mul_q30(trig.cp, trig.sy);
            sysr_reg <= e2r_pkg::mul_q30(trig.sy, trig.sr);
            sycr_reg <= e2r_pkg::mul_q30(trig.sy, trig.cr);
            cysr_reg <= e2r_pkg::mul_q30(trig.cy, trig.sr);
            cycr_reg <= e2r_pkg::mul_q30(trig.cy, trig.cr);
            sp1_reg  <= trig.sp;
            cr1_reg  <= trig.cr;
            sr1_reg  <= trig.sr;
        end
    end

    // Triple products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= e2r_pkg::mul_q30(spcy_reg, cr1_reg);
            b_reg     <= e2r_pkg::mul_q30(spcy_reg, sr1_reg);
            c_reg     <= e2r_pkg::mul_q30(spsy_reg, cr1_reg);
            d_reg     <= e2r_pkg::mul_q30(spsy_reg, sr1_reg);
            cpcy2_reg <= cpcy_reg;
            cpcr2_reg <= cpcr_reg;
            cpsr2_reg <= cpsr_reg;
            cpsy2_reg <= cpsy_reg;
            sysr2_reg <= sysr_reg;
            sycr2_reg <= sycr_reg;
            cysr2_reg <= cysr_reg;
            cycr2_reg <= cycr_reg;
            sp2_reg   <= sp1_reg;
        end
    end

    // Sum pairs and pack the elements
    always_comb
    begin
        data_next = {
            to_out(33'(cycr2_reg) - 33'(d_reg)),
            to_out(33'(c_reg) + 33'(cysr2_reg)),
            to_out(-33'(cpsy2_reg)),
            to_out(-33'(cpsr2_reg)),
            to_out(33'(cpcr2_reg)),
            to_out(33'(sp2_reg)),
            to_out(33'(b_reg) + 33'(sycr2_reg)),
            to_out(33'(sysr2_reg) - 33'(a_reg)),
            to_out(33'(cpcy2_reg))
        };
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = vo_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/euler_to_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Euler angles (pitch, yaw, roll) to body-to-launch rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one angle triple per transfer; m_axis returns the nine
//   matrix elements of that triple, in order, one transfer per input.
//   Throughput: one transfer per cycle when m_axis is not stalled.
//   Each CORDIC lane registers the loaded angle, every iteration and the
//   unfolded quadrant; the queue stores each set, and the back end registers
//   the double products, the triple products and the packed elements.
//   A four-entry queue parts the CORDIC front from the multiply back end.
//   When m_axis_tready is low the back end holds its result; the queue
//   fills and the front holds its pipeline, dropping s_axis_tready only
//   while a finished set cannot enter the queue.
//   Reset clears all valid flags and the queue; no item is in flight after it.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = e2r_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pitch_angle, yaw_angle, roll_angle, zero pad
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W  = 9 * (FRAC_BITS + 2);
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    e2r_pkg::queue_stat_t q_stat;
    e2r_pkg::trig_t       f_trig, q_trig;
    logic                 push, pop;
    logic [OUT_W-1:0]     out_data;

    e2r_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .pitch_angle(s_axis_tdata[ANGLE_BITS-1:0]),
        .yaw_angle  (s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .roll_angle (s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .q_stat     (q_stat),
        .push       (push),
        .trig       (f_trig)
    );

    e2r_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(f_trig),
        .pop  (pop),
        .rdata(q_trig),
        .stat (q_stat)
    );

    e2r_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .trig     (q_trig),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_data)
    );

    // Pad the result to whole bytes
    assign m_axis_tdata = OUT_TW'(out_data);

endmodule

// ===== hdl/e2r_checker.sv =====
// ----------------------------------------------------------------------------
// e2r_checker
// Port-level checks of the Euler angle to rotation matrix block.
// ----------------------------------------------------------------------------
`include "euler_to_rotation_matrix_top_macros.svh"

module e2r_checker #(
    parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = e2r_pkg::FRAC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OW = FRAC_BITS + 2;

    logic signed [OW-1:0] m10;
    logic signed [OW-1:0] m12;

    assign m10 = $signed(m_axis_tdata[4*OW-1:3*OW]);
    assign m12 = $signed(m_axis_tdata[6*OW-1:5*OW]);

    // No result is shown during reset
    `E2R_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n, !m_axis_tvalid)

    // A stalled result holds
    `E2R_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // Sine of pitch stays within plus or minus one
    `E2R_ASSERT_SAME(a_m10_range, m_axis_tvalid,
                     (m10 <= (OW'(1) <<< FRAC_BITS)) && (m10 >= -(OW'(1) <<< FRAC_BITS)))

    // Element in row 1 column 2 stays within plus or minus one
    `E2R_ASSERT_SAME(a_m12_range, m_axis_tvalid,
                     (m12 <= (OW'(1) <<< FRAC_BITS)) && (m12 >= -(OW'(1) <<< FRAC_BITS)))

endmodule

bind euler_to_rotation_matrix_top e2r_checker #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_e2r_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/euler_to_rotation_matrix_top_tb.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top_tb
// Streams angle triples into the rotation matrix block and checks every
// matrix against a bit-exact CORDIC and product model, with random gaps on
// both stream sides.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB = e2r_pkg::ANGLE_BITS_DEF;
    localparam int FB = e2r_pkg::FRAC_BITS_DEF;
    localparam int EW = FB + 2;
    localparam int SW = ((3*AB+7)/8)*8;
    localparam int MW = ((9*EW+7)/8)*8;
    localparam int ITERS = 30;
    localparam longint ONE = 64'sd1073741824;
    localparam longint GAIN = 64'sd652032874;
    localparam longint LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [MW-1:0] m_axis_tdata;

    typedef logic [9*EW-1:0] matrix_t;

    matrix_t matrix_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    longint cycles = 0;

    euler_to_rotation_matrix_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[euler_to_rotation_matrix_top] ERROR");
            $finish;
        end
    end

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return fshift(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic longint clampq(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint atan_turn(int i);
        longint t [ITERS] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
            'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
            'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
            'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
            'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
            'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
        return t[i];
    endfunction

    // Sine and cosine in Q30 by rotation-mode CORDIC with quadrant folding
    function automatic void sine_cosine(input logic [AB-1:0] ang, output longint s,
                                        output longint c);
        logic [31:0] phase;
        longint x, y, z, dx, dy;
        phase = {ang, {(32-AB){1'b0}}};
        z = longint'(phase[29:0]);
        x = GAIN;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_turn(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_turn(i);
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c = clampq(c);
        s = clampq(s);
    endfunction

    function automatic logic [EW-1:0] to_elem(longint q);
        int sh;
        longint v, lim;
        sh = 30 - FB;
        v = (sh > 0) ? fshift(q + (64'sd1 << (sh - 1)), sh) : q;
        lim = 64'sd1 << FB;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[EW-1:0];
    endfunction

    function automatic matrix_t rotation_matrix(logic [AB-1:0] p, logic [AB-1:0] yw,
                                                logic [AB-1:0] r);
        longint sp, cp, sy, cy, sr, cr, spcy, spsy;
        matrix_t m;
        sine_cosine(p, sp, cp);
        sine_cosine(yw, sy, cy);
        sine_cosine(r, sr, cr);
        spcy = qmul(sp, cy);
        spsy = qmul(sp, sy);
        m[0*EW +: EW] = to_elem(qmul(cp, cy));
        m[1*EW +: EW] = to_elem(-qmul(spcy, cr) + qmul(sy, sr));
        m[2*EW +: EW] = to_elem(qmul(spcy, sr) + qmul(sy, cr));
        m[3*EW +: EW] = to_elem(sp);
        m[4*EW +: EW] = to_elem(qmul(cp, cr));
        m[5*EW +: EW] = to_elem(-qmul(cp, sr));
        m[6*EW +: EW] = to_elem(-qmul(cp, sy));
        m[7*EW +: EW] = to_elem(qmul(spsy, cr) + qmul(cy, sr));
        m[8*EW +: EW] = to_elem(-qmul(spsy, sr) + qmul(cy, cr));
        return m;
    endfunction

    // Send one angle triple, with a random gap before it
    task automatic send_angles(input logic [AB-1:0] p, input logic [AB-1:0] yw,
                               input logic [AB-1:0] r, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= SW'({r, yw, p});
        s_axis_tvalid <= 1'b1;
        matrix_q.push_back(rotation_matrix(p, yw, r));
        do @(posedge clk); while (!s_axis_tready);
        n_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls, compare each transfer with the oldest matrix
    initial
    begin
        matrix_t exp_m, got;
        int stall;
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && rst_n));
            got = m_axis_tdata[9*EW-1:0];
            if (matrix_q.size() == 0)
            begin
                $display("%0t: unexpected matrix %h", $time, got);
                errors++;
            end
            else
            begin
                exp_m = matrix_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k*EW +: EW] !== exp_m[k*EW +: EW])
                    begin
                        $display("%0t: element m%0d%0d expected %h got %h", $time,
                                 k / 3, k % 3, exp_m[k*EW +: EW], got[k*EW +: EW]);
                        errors++;
                    end
                n_checked++;
            end
        end
    end

    localparam logic [AB-1:0] NEG_PI = {1'b1, {(AB-1){1'b0}}};
    localparam logic [AB-1:0] MAX_A  = {1'b0, {(AB-1){1'b1}}};
    localparam logic [AB-1:0] QTR    = {2'b01, {(AB-2){1'b0}}};

    // Extremes, quadrant edges and minus pi on each axis
    task automatic test_directed();
        logic [AB-1:0] v [8] = '{'0, NEG_PI, MAX_A, QTR, -QTR, '1, AB'(1), AB'(QTR + 1)};
        for (int i = 0; i < 8; i++)
            send_angles(v[i], v[(i + 3) % 8], v[(i + 5) % 8], 0);
        send_angles(NEG_PI, NEG_PI, NEG_PI, 0);
        send_angles(MAX_A, MAX_A, MAX_A, 0);
        send_angles(QTR, QTR, QTR, 0);
        send_angles(-QTR, QTR, -QTR, 0);
    endtask

    // Random triples; runs with gaps and runs back to back
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_angles(AB'($urandom), AB'($urandom), AB'($urandom),
                        ((i / 100) % 2) ? 10 : 0);
    endtask

    // Pitch and yaw near the quadrant boundaries and the wrap point, roll at random
    task automatic test_boundaries(input int n);
        logic [AB-1:0] b [4] = '{'0, QTR, NEG_PI, -QTR};
        for (int i = 0; i < n; i++)
            send_angles(AB'(b[$urandom_range(0, 3)] + AB'($urandom_range(0, 6)) - 3),
                        AB'(b[$urandom_range(0, 3)] + AB'($urandom_range(0, 6)) - 3),
                        AB'($urandom), $urandom_range(0, 1) ? 10 : 0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(1300);
        test_boundaries(200);
        s_axis_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d angle triples, checked %0d matrices (extremes, quadrant edges,",
                 n_sent, n_checked);
        $display("random angles, random gaps and stalls on both sides).");
        if (errors == 0)
            $display("[euler_to_rotation_matrix_top] OK");
        else
            $display("[euler_to_rotation_matrix_top] ERROR");
        $finish;
    end
endmodule
